>>> hw/rtl/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg: shared types and constants of the bounded positional list
// Holds the capacity, field widths, operation and status codes, the
// transaction structs of both channels and the command that drives the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpl_pkg;

  // Number of cells in the row (2 to 63).
  localparam int CAPACITY = 32;

  // Field widths fixed by the interface.
  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 6;

  // Internal widths that follow from the capacity.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // Operation codes; code seven is a no-operation.
  localparam logic [OP_W-1:0] OP_ADD_FIRST = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_LAST  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AT = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_DISPLAY   = 3'd6;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  // Request transaction.
  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  // Result transaction.
  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] value_out;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } res_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CK_HOLD,
    CK_INSERT,
    CK_DELETE,
    CK_ROTATE
  } cell_op_e;

  // Command broadcast along the row of cells.
  typedef struct packed {
    cell_op_e                kind;
    logic [IDX_W-1:0]        idx;
    logic [IDX_W-1:0]        tail;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

>>> hw/rtl/bpl_cell.sv
// ----------------------------------------------------------------------------
// bpl_cell: one storage cell of the list
// Holds one entry and, on each broadcast command, keeps it, loads a new
// value, or takes the entry of its left, right or head neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpl_cell
  import bpl_pkg::*;
(
  input  logic                    clk_i,
  input  logic [IDX_W-1:0]        cell_idx_i,
  input  cell_cmd_t               cmd_i,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  input  logic signed [VAL_W-1:0] head_i,
  output logic signed [VAL_W-1:0] value_o
);

  logic signed [VAL_W-1:0] value_d, value_q;

  // Choose the next entry from the command and this cell's place in the row.
  always_comb begin
    value_d = value_q;
    unique case (cmd_i.kind)
      CK_INSERT: begin
        if (cell_idx_i > cmd_i.idx) begin
          value_d = left_i;
        end else if (cell_idx_i == cmd_i.idx) begin
          value_d = cmd_i.value;
        end
      end
      CK_DELETE: begin
        if (cell_idx_i >= cmd_i.idx) begin
          value_d = right_i;
        end
      end
      CK_ROTATE: begin
        if (cell_idx_i < cmd_i.tail) begin
          value_d = right_i;
        end else if (cell_idx_i == cmd_i.tail) begin
          value_d = head_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // The entry is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> hw/rtl/bpl_chain.sv
// ----------------------------------------------------------------------------
// bpl_chain: row of list cells
// Links the cells to their neighbours so that inserts shift towards the
// tail, deletes shift towards the head and a display rotates the entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpl_chain
  import bpl_pkg::*;
(
  input  logic                    clk_i,
  input  cell_cmd_t               cmd_i,
  output logic signed [VAL_W-1:0] cells_o [CAPACITY]
);

  // Each cell sees its neighbours; the ends see themselves, which only fills a cell beyond the last entry.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VAL_W-1:0] left, right;

    if (g == 0) begin : g_first
      assign left = cells_o[0];
    end else begin : g_inner_l
      assign left = cells_o[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right = cells_o[CAPACITY-1];
    end else begin : g_inner_r
      assign right = cells_o[g+1];
    end

    bpl_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .cmd_i      (cmd_i),
      .left_i     (left),
      .right_i    (right),
      .head_i     (cells_o[0]),
      .value_o    (cells_o[g])
    );
  end

endmodule

>>> hw/rtl/bounded_positional_list_top.sv
// ----------------------------------------------------------------------------
// bounded_positional_list_top: ordered list of signed words in shifting cells
// Decodes each request into one command for the row of cells and reports
// status, removed value and count, or streams the list for a display.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                       Direction  Transfer
//  request   start_i, busy_o, req_i        in         start_i high, busy_o low
//  result    result_valid_o, result_o      out        one-cycle strobe
//
//  The result of an edit or an empty display appears on the cycle after
//  acceptance, and the next request may come in that same cycle.
//  A display of a non-empty list moves to S_SHOW and holds busy_o while
//  the row of cells rotates once; the head entry of each rotation step is
//  registered as a result, one result per cycle, and the next request may
//  come in the cycle of the final result.
//  Reset empties the list at once. Results cannot be stalled.
//
`timescale 1ns / 1ps

module bounded_positional_list_top
  import bpl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic result_valid_o,
  output res_t result_o
);

  typedef enum logic {
    S_IDLE,
    S_SHOW
  } state_e;

  state_e                  state_d, state_q;
  logic [CNT_W-1:0]        cnt_d, cnt_q;
  logic [CNT_W-1:0]        remain_d, remain_q;
  logic                    valid_d, valid_q;
  res_t                    res_d, res_q;
  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cells [CAPACITY];
  logic                    accept;
  logic                    full, empty;
  logic [CMP_W-1:0]        pos_x, cnt_x;
  logic [IDX_W-1:0]        del_idx;

  assign accept = start_i && (state_q == S_IDLE);
  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign empty  = (cnt_q == '0);
  assign pos_x  = CMP_W'(req_i.position);
  assign cnt_x  = CMP_W'(cnt_q);

  // Position of the entry a delete removes.
  always_comb begin
    case (req_i.opcode)
      OP_DEL_FIRST: del_idx = '0;
      OP_DEL_LAST:  del_idx = IDX_W'(cnt_q - 1'b1);
      default:      del_idx = IDX_W'(req_i.position - 1'b1);
    endcase
  end

  // Request decode, cell command and result formation.
  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    remain_d        = remain_q;
    valid_d         = 1'b0;
    res_d           = res_q;
    cmd.kind        = CK_HOLD;
    cmd.idx         = '0;
    cmd.tail        = IDX_W'(cnt_q - 1'b1);
    cmd.value       = req_i.value;
    res_d.status    = STAT_OK;
    res_d.value_out = '0;
    res_d.last      = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          valid_d = 1'b1;
          case (req_i.opcode)
            OP_ADD_FIRST, OP_ADD_LAST: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                cmd.kind = CK_INSERT;
                cmd.idx  = (req_i.opcode == OP_ADD_FIRST) ? '0 : IDX_W'(cnt_q);
                cnt_d    = cnt_q + 1'b1;
              end
            end
            OP_INSERT_AT: begin
              if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                res_d.status = STAT_BADPOS;
              end else if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                cmd.kind = CK_INSERT;
                cmd.idx  = IDX_W'(req_i.position - 1'b1);
                cnt_d    = cnt_q + 1'b1;
              end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else if (req_i.opcode == OP_DEL_AT &&
                           (pos_x == '0 || pos_x > cnt_x)) begin
                res_d.status = STAT_BADPOS;
              end else begin
                cmd.kind        = CK_DELETE;
                cmd.idx         = del_idx;
                res_d.value_out = cells[del_idx];
                cnt_d           = cnt_q - 1'b1;
              end
            end
            OP_DISPLAY: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                // The entries stream out from state S_SHOW on.
                valid_d  = 1'b0;
                remain_d = cnt_q;
                state_d  = S_SHOW;
              end
            end
            default: res_d.status = STAT_OK;
          endcase
        end
      end
      S_SHOW: begin
        // Emit the head entry and rotate it to the tail.
        valid_d         = 1'b1;
        cmd.kind        = CK_ROTATE;
        res_d.value_out = cells[0];
        res_d.last      = (remain_q == CNT_W'(1));
        remain_d        = remain_q - 1'b1;
        if (remain_q == CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    res_d.count = COUNT_W'(cnt_d);
  end

  // State, count and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      remain_q <= '0;
      valid_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      remain_q <= remain_d;
      valid_q  <= valid_d;
      res_q    <= res_d;
    end
  end

  bpl_chain u_chain (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .cells_o (cells)
  );

  assign busy_o         = (state_q == S_SHOW);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

>>> hw/rtl/bpl_checker.sv
// ----------------------------------------------------------------------------
// bpl_checker: port-level checks of the bounded positional list
// Watches the request and result ports for the timing between accepted
// transactions, busy and result strobes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpl_checker
  import bpl_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input req_t req_i,
  input logic result_valid_o,
  input res_t result_o
);

  // Every accepted transaction gives a result on the next cycle, unless a
  // display of a non-empty list has started streaming.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> result_valid_o || busy_o)
    else $error("accepted transaction gave no result");

  // Only a display may raise busy.
  a_edit_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_i.opcode != OP_DISPLAY |=> !busy_o)
    else $error("busy raised by an edit");

  // While busy, a result streams out on the following cycle.
  a_busy_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> result_valid_o)
    else $error("display stream has a gap");

  // Busy drops together with the final result of a display.
  a_fell_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o && result_o.last)
    else $error("busy dropped without a final result");

  // A result that is not final belongs to an ongoing display.
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("non-final result outside a display");

endmodule

bind bounded_positional_list_top bpl_checker u_bpl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
